// ===== design/sst_pkg.sv =====
// Shared types, codes and constants for the socket slot table.
// Used by every module of the block; it depends on nothing else.
package sst_pkg;

    localparam int SLOT_DEPTH          = 32;
    localparam int SLOT_ADDR_W         = 5;
    localparam int NUM_SOCKETS_DEFAULT = 32;

    localparam logic [15:0] PORT_BASE = 16'd1024;
    localparam logic [15:0] PORT_SPAN = 16'd64000;

    // Round-trip class of each slot: one plus the slot index modulo five.
    localparam logic [2:0] DELAY_TABLE [SLOT_DEPTH] = '{
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2, 3'd3,
        3'd4, 3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1,
        3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd5, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd2
    };

    typedef enum logic [2:0] {
        OP_CONNECT = 3'd0,
        OP_SEND    = 3'd1,
        OP_RECEIVE = 3'd2,
        OP_CLOSE   = 3'd3,
        OP_DGRAM   = 3'd4,
        OP_PING    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_FIND = 9'b000000010,
        S_PORT = 9'b000000100,
        S_WRAP = 9'b000001000,
        S_SEQ  = 9'b000010000,
        S_TXP  = 9'b000100000,
        S_TXB  = 9'b001000000,
        S_RXP  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [31:0] remote_address;
        logic [15:0] remote_port;
        logic [15:0] local_port;
        logic [2:0]  delay_class;
        logic [31:0] sequence_count;
    } slot_entry_t;

    // Everything the shared adder may take as an operand.
    typedef struct packed {
        logic [SLOT_DEPTH-1:0] open_vec;
        logic [15:0]           port_counter;
        logic [31:0]           sequence_count;
        logic [31:0]           pkt_out_total;
        logic [31:0]           byte_out_total;
        logic [31:0]           pkt_in_total;
        logic [31:0]           amount;
        logic                  rx_by_amount;
    } operands_t;

endpackage

// ===== design/sst_slot_mem.sv =====
// Per-slot record store: one write port and one registered read port.
// Depends on sst_pkg for the entry type and the depth.
module sst_slot_mem (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [sst_pkg::SLOT_ADDR_W-1:0]  wr_addr,
    input  sst_pkg::slot_entry_t             wr_data,
    input  logic                             rd_en,
    input  logic [sst_pkg::SLOT_ADDR_W-1:0]  rd_addr,
    output sst_pkg::slot_entry_t             rd_data
);
    import sst_pkg::*;

    slot_entry_t mem [SLOT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/sst_add_unit.sv =====
// The one 32-bit adder of the block, with its operand selection by sequencer step.
// Depends on sst_pkg for the step codes and the operand bundle.
module sst_add_unit (
    input  sst_pkg::state_t    state,
    input  sst_pkg::operands_t ops,
    output logic [31:0]        sum
);
    import sst_pkg::*;

    logic [31:0] op_a;
    logic [31:0] op_b;

    always_comb
    begin
        unique case (state)
            S_FIND:
            begin
                op_a = 32'(ops.open_vec);
                op_b = 32'd1;
            end
            S_PORT:
            begin
                op_a = {16'd0, ops.port_counter};
                op_b = {16'd0, PORT_BASE};
            end
            S_WRAP:
            begin
                op_a = {16'd0, ops.port_counter};
                op_b = 32'd1;
            end
            S_SEQ:
            begin
                op_a = ops.sequence_count;
                op_b = ops.amount;
            end
            S_TXP:
            begin
                op_a = ops.pkt_out_total;
                op_b = 32'd1;
            end
            S_TXB:
            begin
                op_a = ops.byte_out_total;
                op_b = ops.amount;
            end
            S_RXP:
            begin
                op_a = ops.pkt_in_total;
                op_b = ops.rx_by_amount ? ops.amount : 32'd1;
            end
            default:
            begin
                op_a = 32'd0;
                op_b = 32'd0;
            end
        endcase
    end

    assign sum = op_a + op_b;

endmodule

// ===== design/socket_slot_table.sv =====
// Top level of the socket slot table: sequencer, slot flags, counters and result register.
// Depends on sst_pkg, sst_slot_mem and sst_add_unit.
//
// The socket slot table keeps up to NUM_SOCKETS connection slots and three shared
// traffic counters. Each input item is one request: connect, stream send, stream
// receive, close, datagram send or ping, and each request gives exactly one result
// item that carries a status, the operation's own outputs and the counter values as
// they stand after the request. One request is in the block at a time: in_stall is
// high from the cycle after an item is accepted until its result has been taken.
// All arithmetic runs through a single 32-bit adder that a small sequencer steps
// through one add per cycle: each request takes one step per add it needs, then
// a result step. A connect steps through free-slot search, local port, port counter
// wrap, packet counter and result, or search and result when no slot is free. A
// stream send steps through sequence count, packets, bytes and result, a datagram
// send packets, bytes and result, receive and ping a receive count and result, close
// packets and result, and a rejected request or an unknown operation code only the
// result. The free-slot search itself is an add: adding one to the open flags, with
// slots beyond NUM_SOCKETS counted as open, leaves the lowest closed slot as the
// only bit that both the sum and the inverted flags hold. The per-slot records live
// in a small memory with a registered read, which is why a stream send reads its
// slot while it is being accepted. No clearing pass is needed after reset: records
// are not reset, and a record is used only after a connect has written it.
module socket_slot_table #(
    parameter int NUM_SOCKETS = sst_pkg::NUM_SOCKETS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [5:0]  slot_index,
    input  logic [31:0] remote_address,
    input  logic [15:0] remote_port,
    input  logic [31:0] amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [4:0]  granted_slot,
    output logic [31:0] returned_value,
    output logic [15:0] local_port,
    output logic [2:0]  delay_class,
    output logic [31:0] sequence_now,
    output logic [31:0] sent_packets,
    output logic [31:0] received_packets,
    output logic [31:0] sent_bytes
);
    import sst_pkg::*;

    // Slots at or above NUM_SOCKETS look permanently open to the search.
    function automatic logic [SLOT_DEPTH-1:0] build_mask();
        logic [SLOT_DEPTH-1:0] m;
        m = '0;
        for (int i = 0; i < SLOT_DEPTH; i++)
        begin
            m[i] = (i >= NUM_SOCKETS);
        end
        return m;
    endfunction

    // Index of the single set bit of a one-hot vector.
    function automatic logic [SLOT_ADDR_W-1:0] onehot_index(input logic [SLOT_DEPTH-1:0] v);
        logic [SLOT_ADDR_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOT_DEPTH; i++)
        begin
            if (v[i])
            begin
                idx = idx | SLOT_ADDR_W'(i);
            end
        end
        return idx;
    endfunction

    localparam logic [SLOT_DEPTH-1:0] SLOT_MASK    = build_mask();
    localparam logic [6:0]            NUM_SOCKETS_W = 7'(NUM_SOCKETS);

    state_t                 state_reg, state_next;
    logic [SLOT_DEPTH-1:0]  open_reg, open_next;
    logic [15:0]            port_counter_reg, port_counter_next;
    logic [31:0]            tx_pkt_reg, tx_pkt_next;
    logic [31:0]            rx_pkt_reg, rx_pkt_next;
    logic [31:0]            tx_bytes_reg, tx_bytes_next;

    // Request and result payload registers.
    logic [2:0]             op_reg, op_next;
    logic [SLOT_ADDR_W-1:0] slot_reg, slot_next;
    logic [31:0]            amount_reg, amount_next;
    logic [31:0]            raddr_reg, raddr_next;
    logic [15:0]            rport_reg, rport_next;
    status_t                status_reg, status_next;
    logic [4:0]             granted_reg, granted_next;
    logic [31:0]            retval_reg, retval_next;
    logic [15:0]            lport_reg, lport_next;
    logic [2:0]             dclass_reg, dclass_next;
    logic [31:0]            seqnow_reg, seqnow_next;

    logic                   in_accept;
    logic                   index_ok;
    logic                   slot_is_open;
    logic [SLOT_DEPTH-1:0]  search_vec;
    logic [SLOT_DEPTH-1:0]  free_onehot;
    logic [SLOT_ADDR_W-1:0] free_index;
    logic [31:0]            sum;
    operands_t              ops;
    logic                   mem_wr_en;
    slot_entry_t            mem_wr_data;
    slot_entry_t            mem_rd_data;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign in_accept = in_valid && !in_stall;

    assign index_ok     = ({1'b0, slot_index} < NUM_SOCKETS_W);
    assign slot_is_open = open_reg[slot_index[SLOT_ADDR_W-1:0]];

    assign search_vec  = open_reg | SLOT_MASK;
    assign free_onehot = ~search_vec & sum[SLOT_DEPTH-1:0];
    assign free_index  = onehot_index(free_onehot);

    always_comb
    begin
        ops.open_vec       = search_vec;
        ops.port_counter   = port_counter_reg;
        ops.sequence_count = mem_rd_data.sequence_count;
        ops.pkt_out_total  = tx_pkt_reg;
        ops.byte_out_total = tx_bytes_reg;
        ops.pkt_in_total   = rx_pkt_reg;
        ops.amount         = amount_reg;
        ops.rx_by_amount   = (op_reg == OP_PING);
    end

    sst_add_unit u_add (
        .state (state_reg),
        .ops   (ops),
        .sum   (sum)
    );

    // The slot record is read while a request is taken, so a send finds it ready.
    sst_slot_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_reg),
        .wr_data (mem_wr_data),
        .rd_en   (in_accept),
        .rd_addr (slot_index[SLOT_ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        state_next        = state_reg;
        open_next         = open_reg;
        port_counter_next = port_counter_reg;
        tx_pkt_next       = tx_pkt_reg;
        rx_pkt_next       = rx_pkt_reg;
        tx_bytes_next     = tx_bytes_reg;
        op_next           = op_reg;
        slot_next         = slot_reg;
        amount_next       = amount_reg;
        raddr_next        = raddr_reg;
        rport_next        = rport_reg;
        status_next       = status_reg;
        granted_next      = granted_reg;
        retval_next       = retval_reg;
        lport_next        = lport_reg;
        dclass_next       = dclass_reg;
        seqnow_next       = seqnow_reg;
        mem_wr_en         = 1'b0;
        mem_wr_data       = mem_rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = operation;
                    slot_next    = slot_index[SLOT_ADDR_W-1:0];
                    amount_next  = amount;
                    raddr_next   = remote_address;
                    rport_next   = remote_port;
                    status_next  = ST_OK;
                    granted_next = '0;
                    retval_next  = '0;
                    lport_next   = '0;
                    dclass_next  = '0;
                    seqnow_next  = '0;
                    case (operation)
                        OP_CONNECT:
                        begin
                            state_next = S_FIND;
                        end
                        OP_SEND:
                        begin
                            if (index_ok && slot_is_open)
                            begin
                                retval_next = amount;
                                state_next  = S_SEQ;
                            end
                            else
                            begin
                                status_next = ST_BAD;
                                state_next  = S_DONE;
                            end
                        end
                        OP_RECEIVE:
                        begin
                            if (index_ok && slot_is_open)
                            begin
                                state_next = S_RXP;
                            end
                            else
                            begin
                                status_next = ST_BAD;
                                state_next  = S_DONE;
                            end
                        end
                        OP_CLOSE:
                        begin
                            // Closing a slot that is already closed still succeeds.
                            if (index_ok)
                            begin
                                open_next[slot_index[SLOT_ADDR_W-1:0]] = 1'b0;
                                state_next = S_TXP;
                            end
                            else
                            begin
                                status_next = ST_BAD;
                                state_next  = S_DONE;
                            end
                        end
                        OP_DGRAM:
                        begin
                            retval_next = amount;
                            state_next  = S_TXP;
                        end
                        OP_PING:
                        begin
                            retval_next = amount;
                            state_next  = S_RXP;
                        end
                        default:
                        begin
                            status_next = ST_BAD;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (|free_onehot)
                begin
                    open_next[free_index] = 1'b1;
                    slot_next             = free_index;
                    granted_next          = 5'(free_index);
                    dclass_next           = DELAY_TABLE[free_index];
                    state_next            = S_PORT;
                end
                else
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
            end
            S_PORT:
            begin
                lport_next = sum[15:0];
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                port_counter_next = (sum[15:0] >= PORT_SPAN) ? 16'd0 : sum[15:0];
                mem_wr_en                  = 1'b1;
                mem_wr_data.remote_address = raddr_reg;
                mem_wr_data.remote_port    = rport_reg;
                mem_wr_data.local_port     = lport_reg;
                mem_wr_data.delay_class    = dclass_reg;
                mem_wr_data.sequence_count = '0;
                state_next = S_TXP;
            end
            S_SEQ:
            begin
                mem_wr_en                  = 1'b1;
                mem_wr_data.sequence_count = sum;
                seqnow_next                = sum;
                state_next                 = S_TXP;
            end
            S_TXP:
            begin
                tx_pkt_next = sum;
                if (op_reg == OP_SEND || op_reg == OP_DGRAM)
                begin
                    state_next = S_TXB;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TXB:
            begin
                tx_bytes_next = sum;
                state_next    = S_DONE;
            end
            S_RXP:
            begin
                rx_pkt_next = sum;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            open_reg         <= '0;
            port_counter_reg <= '0;
            tx_pkt_reg       <= '0;
            rx_pkt_reg       <= '0;
            tx_bytes_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            open_reg         <= open_next;
            port_counter_reg <= port_counter_next;
            tx_pkt_reg       <= tx_pkt_next;
            rx_pkt_reg       <= rx_pkt_next;
            tx_bytes_reg     <= tx_bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        slot_reg    <= slot_next;
        amount_reg  <= amount_next;
        raddr_reg   <= raddr_next;
        rport_reg   <= rport_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        retval_reg  <= retval_next;
        lport_reg   <= lport_next;
        dclass_reg  <= dclass_next;
        seqnow_reg  <= seqnow_next;
    end

    assign status           = status_reg;
    assign granted_slot     = granted_reg;
    assign returned_value   = retval_reg;
    assign local_port       = lport_reg;
    assign delay_class      = dclass_reg;
    assign sequence_now     = seqnow_reg;
    assign sent_packets     = tx_pkt_reg;
    assign received_packets = rx_pkt_reg;
    assign sent_bytes       = tx_bytes_reg;

`ifndef SYNTHESIS
    // An accepted request always leaves the idle state on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    // The packet step adds exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TXP |=> tx_pkt_reg == $past(tx_pkt_reg) + 32'd1)
        else $error("transmit packet counter stepped wrongly");

    // A full report means every usable slot really is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg == ST_FULL) |-> &(open_reg | SLOT_MASK))
        else $error("full reported while a slot was free");

    // Open flags change only during the search or when a close is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(open_reg) |-> ($past(state_reg) == S_FIND || $past(state_reg) == S_IDLE))
        else $error("open flags changed outside search or close");
`endif

endmodule

// ===== test/socket_slot_table_tb.sv =====
// Self-checking testbench for the socket slot table: random and directed requests,
// random idling on both channels, every result checked against a local prediction.
// Depends on sst_pkg and the socket_slot_table RTL.
`timescale 1ns / 1ps

module socket_slot_table_tb;

    import sst_pkg::*;

    localparam int NSOCK = sst_pkg::NUM_SOCKETS_DEFAULT;

    // Operation codes that the table does not define.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [5:0]  idx;
        logic [31:0] addr;
        logic [15:0] rport;
        logic [31:0] amt;
    } request_t;

    typedef struct {
        status_t     status;
        logic [4:0]  granted;
        logic [31:0] retval;
        logic [15:0] lport;
        logic [2:0]  dclass;
        logic [31:0] seqnow;
        logic [31:0] txp;
        logic [31:0] rxp;
        logic [31:0] txb;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = '0;
    logic [5:0]  slot_index = '0;
    logic [31:0] remote_address = '0;
    logic [15:0] remote_port = '0;
    logic [31:0] amount = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [4:0]  granted_slot;
    logic [31:0] returned_value;
    logic [15:0] local_port;
    logic [2:0]  delay_class;
    logic [31:0] sequence_now;
    logic [31:0] sent_packets;
    logic [31:0] received_packets;
    logic [31:0] sent_bytes;

    // Requests waiting to be driven and replies waiting to be seen.
    request_t request_q[$];
    reply_t   reply_q[$];
    int       mismatch_count = 0;
    // While set, neither side idles nor stalls.
    bit       quiet = 1'b0;

    // Predicted table state. Remote address and port are never returned, so they
    // are not tracked.
    logic [NSOCK-1:0] open_flags = '0;
    logic [31:0]      slot_seq [NSOCK];
    logic [15:0]      port_ctr = '0;
    logic [31:0]      tx_pkts = '0;
    logic [31:0]      rx_pkts = '0;
    logic [31:0]      byte_total = '0;

    socket_slot_table #(.NUM_SOCKETS(NSOCK)) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .slot_index       (slot_index),
        .remote_address   (remote_address),
        .remote_port      (remote_port),
        .amount           (amount),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .granted_slot     (granted_slot),
        .returned_value   (returned_value),
        .local_port       (local_port),
        .delay_class      (delay_class),
        .sequence_now     (sequence_now),
        .sent_packets     (sent_packets),
        .received_packets (received_packets),
        .sent_bytes       (sent_bytes)
    );

    always #4 clk = ~clk;

    // Applies one request to the predicted table and returns the reply it should give.
    function automatic reply_t apply_request(input logic [2:0] op, input logic [5:0] idx,
                                             input logic [31:0] amt);
        reply_t r;
        bit     found;
        bit     idx_ok;
        r.status  = ST_OK;
        r.granted = '0;
        r.retval  = '0;
        r.lport   = '0;
        r.dclass  = '0;
        r.seqnow  = '0;
        found     = 1'b0;
        idx_ok    = (idx < NSOCK);
        case (op)
            OP_CONNECT:
            begin
                r.status = ST_FULL;
                for (int i = 0; i < NSOCK; i++)
                begin
                    if (!found && !open_flags[i])
                    begin
                        found         = 1'b1;
                        open_flags[i] = 1'b1;
                        slot_seq[i]   = '0;
                        r.lport       = PORT_BASE + port_ctr;
                        r.dclass      = 3'(1 + i % 5);
                        r.granted     = 5'(i);
                        r.status      = ST_OK;
                        port_ctr      = (port_ctr == PORT_SPAN - 16'd1) ? '0 : port_ctr + 16'd1;
                        tx_pkts       = tx_pkts + 32'd1;
                    end
                end
            end
            OP_SEND:
            begin
                if (!idx_ok || !open_flags[idx[4:0]])
                    r.status = ST_BAD;
                else
                begin
                    slot_seq[idx[4:0]] = slot_seq[idx[4:0]] + amt;
                    r.seqnow   = slot_seq[idx[4:0]];
                    r.retval   = amt;
                    tx_pkts    = tx_pkts + 32'd1;
                    byte_total = byte_total + amt;
                end
            end
            OP_RECEIVE:
            begin
                if (!idx_ok || !open_flags[idx[4:0]])
                    r.status = ST_BAD;
                else
                    rx_pkts = rx_pkts + 32'd1;
            end
            OP_CLOSE:
            begin
                // Closing a slot that is already closed still succeeds and counts.
                if (!idx_ok)
                    r.status = ST_BAD;
                else
                begin
                    open_flags[idx[4:0]] = 1'b0;
                    tx_pkts = tx_pkts + 32'd1;
                end
            end
            OP_DGRAM:
            begin
                tx_pkts    = tx_pkts + 32'd1;
                byte_total = byte_total + amt;
                r.retval   = amt;
            end
            OP_PING:
            begin
                rx_pkts  = rx_pkts + amt;
                r.retval = amt;
            end
            default:
                r.status = ST_BAD;
        endcase
        r.txp = tx_pkts;
        r.rxp = rx_pkts;
        r.txb = byte_total;
        return r;
    endfunction

    // Request driver. An item is taken at an edge with valid high and stall low; the
    // accepted item is predicted at that edge, and a held item never changes.
    always @(posedge clk)
    begin
        request_t nxt;
        bit       take;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            take = in_valid && !in_stall;
            if (take)
                reply_q.push_back(apply_request(operation, slot_index, amount));
            if (in_valid && !take)
                in_valid <= 1'b1;
            else if (request_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 37))
            begin
                nxt = request_q.pop_front();
                operation      <= nxt.op;
                slot_index     <= nxt.idx;
                remote_address <= nxt.addr;
                remote_port    <= nxt.rport;
                amount         <= nxt.amt;
                in_valid       <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Reply monitor: compares each taken reply with the oldest prediction.
    always @(posedge clk)
    begin
        reply_t w;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                begin
                    $display("%0t: reply with none expected, status %h", $time, status);
                    mismatch_count++;
                end
                else
                begin
                    w = reply_q.pop_front();
                    check_field("status", 32'(w.status), 32'(status));
                    check_field("granted_slot", 32'(w.granted), 32'(granted_slot));
                    check_field("returned_value", w.retval, returned_value);
                    check_field("local_port", 32'(w.lport), 32'(local_port));
                    check_field("delay_class", 32'(w.dclass), 32'(delay_class));
                    check_field("sequence_now", w.seqnow, sequence_now);
                    check_field("sent_packets", w.txp, sent_packets);
                    check_field("received_packets", w.rxp, received_packets);
                    check_field("sent_bytes", w.txb, sent_bytes);
                end
            end
            out_stall <= !quiet && ($urandom_range(0, 99) < 37);
        end
    end

    // Keeps the request queue short so that long runs need little memory.
    task automatic queue_request(input logic [2:0] op, input logic [5:0] idx,
                                 input logic [31:0] amt);
        request_t q;
        while (request_q.size() >= 16)
            @(negedge clk);
        q.op    = op;
        q.idx   = idx;
        q.addr  = $urandom;
        q.rport = 16'($urandom);
        q.amt   = amt;
        request_q.push_back(q);
    endtask

    // Waits until every request has been taken and every reply has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || reply_q.size() != 0);
    endtask

    function automatic logic [31:0] random_amount();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 16)
            return '1;
        else if (r < 50)
            return 32'($urandom_range(0, 4096));
        return $urandom;
    endfunction

    function automatic logic [5:0] random_index();
        int r;
        r = $urandom_range(0, 99);
        // Connects fill the lowest slots, so low indices mostly hit open slots.
        if (r < 50)
            return 6'($urandom_range(0, 7));
        else if (r < 85)
            return 6'($urandom_range(0, NSOCK - 1));
        return 6'($urandom_range(NSOCK, 63));
    endfunction

    // Random traffic: mostly single requests on live slots, with occasional bursts
    // that fill the whole table (and then ask at least twice more) or close every slot.
    task automatic random_traffic(input int count);
        int done_items;
        int r;
        logic [2:0] op;
        done_items = 0;
        while (done_items < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                for (int i = 0; i < NSOCK + 2; i++)
                    queue_request(OP_CONNECT, 6'($urandom), random_amount());
                done_items += NSOCK + 2;
            end
            else if (r < 5)
            begin
                for (int i = NSOCK - 1; i >= 0; i--)
                    queue_request(OP_CLOSE, 6'(i), random_amount());
                done_items += NSOCK;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 22)
                    op = OP_CONNECT;
                else if (r < 47)
                    op = OP_SEND;
                else if (r < 62)
                    op = OP_RECEIVE;
                else if (r < 76)
                    op = OP_CLOSE;
                else if (r < 86)
                    op = OP_DGRAM;
                else if (r < 95)
                    op = OP_PING;
                else
                    op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                queue_request(op, random_index(), random_amount());
                done_items++;
            end
        end
    endtask

    initial
    begin
        int sweep_len;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed opening: closed-slot errors, out-of-range indices, field extremes,
        // sequence and counter wrap, unused operation codes, reuse of the lowest slot.
        queue_request(OP_SEND, 6'd0, 32'd5);
        queue_request(OP_RECEIVE, 6'd0, 32'd0);
        queue_request(OP_CLOSE, 6'd0, 32'd0);
        queue_request(OP_CLOSE, 6'd63, 32'd0);
        queue_request(OP_CONNECT, 6'd0, 32'd0);
        queue_request(OP_CONNECT, 6'd63, 32'hFFFF_FFFF);
        queue_request(OP_SEND, 6'd0, 32'hFFFF_FFFF);
        queue_request(OP_SEND, 6'd0, 32'd1);
        queue_request(OP_SEND, 6'd1, 32'd0);
        queue_request(OP_RECEIVE, 6'd1, 32'd0);
        queue_request(OP_RECEIVE, 6'(NSOCK), 32'd0);
        queue_request(OP_SEND, 6'd63, 32'd7);
        queue_request(OP_DGRAM, 6'd0, 32'hFFFF_FFFF);
        queue_request(OP_DGRAM, 6'd0, 32'd0);
        queue_request(OP_PING, 6'd0, 32'hFFFF_FFFF);
        queue_request(OP_PING, 6'd0, 32'd0);
        queue_request(OP_SPARE_LO, 6'd0, 32'd1);
        queue_request(OP_SPARE_HI, 6'd63, 32'hFFFF_FFFF);
        queue_request(OP_CLOSE, 6'd0, 32'd0);
        queue_request(OP_CONNECT, 6'd42, 32'd0);
        queue_request(OP_CLOSE, 6'(NSOCK - 1), 32'd0);
        queue_request(OP_CLOSE, 6'(NSOCK), 32'd0);

        // Hold off until the table has answered everything before going random.
        wait_drained();
        random_traffic(820);

        // With no idling on either side, cycle slot 0 through connect and close
        // back to back.
        wait_drained();
        quiet = 1'b1;
        queue_request(OP_CLOSE, 6'd0, 32'd0);
        sweep_len = 40;
        for (int i = 0; i < sweep_len; i++)
        begin
            queue_request(OP_CONNECT, 6'($urandom), 32'($urandom));
            queue_request(OP_CLOSE, 6'd0, 32'($urandom));
        end
        wait_drained();
        quiet = 1'b0;

        random_traffic(820);
        wait_drained();
        // Allow a stray late reply to show up before the verdict.
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/sst_pkg.sv
design/sst_slot_mem.sv
design/sst_add_unit.sv
design/socket_slot_table.sv
test/socket_slot_table_tb.sv
